FILE: rtl/core/bdms_pkg.sv
// Shared constants, codes, command/status types and the menu lookup
// for the button debounce / menu select block. No dependencies.
`default_nettype none

package bdms_pkg;

  localparam int NUM_BUTTONS = 5;
  localparam int TICK_BITS   = 32;
  localparam int BTN_W       = $clog2(NUM_BUTTONS);

  // Field widths of the channel words
  localparam int IDX_W    = 3;
  localparam int TICK_IN_W = 32;
  localparam int ENC_W    = 16;
  localparam int CFG_W    = 16;
  localparam int MENU_W   = 2;
  localparam int DIR_W    = 2;
  localparam int STATES_W = 5;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd50;

  localparam logic MODE_EVENT = 1'b0;
  localparam logic MODE_POLL  = 1'b1;

  localparam logic [BTN_W-1:0] MENU_BUTTONS = BTN_W'(4);
  localparam logic [BTN_W-1:0] ENC_PUSH_BTN = BTN_W'(4);

  localparam logic [MENU_W-1:0] MENU_TIMEBASE  = 2'd0;
  localparam logic [MENU_W-1:0] MENU_CHANNELS  = 2'd1;
  localparam logic [MENU_W-1:0] MENU_DIVISIONS = 2'd2;
  localparam logic [MENU_W-1:0] MENU_TRIGGER   = 2'd3;

  localparam logic [DIR_W-1:0] DIR_NONE = 2'd0;
  localparam logic [DIR_W-1:0] DIR_DOWN = 2'd1;
  localparam logic [DIR_W-1:0] DIR_UP   = 2'd2;

  typedef struct packed {
    logic load_item;
    logic ev_cmp;
    logic ev_wr;
    logic scan_clr;
    logic scan_step;
    logic enc_upd;
    logic out_load;
  } bdms_cmd_t;

  typedef struct packed {
    logic scan_last;
  } bdms_sts_t;

  // Menu button to menu mode
  function automatic logic [MENU_W-1:0] menu_of(input logic [1:0] btn);
    logic [MENU_W-1:0] m;
    unique case (btn)
      2'd0:    m = MENU_CHANNELS;
      2'd1:    m = MENU_TIMEBASE;
      2'd2:    m = MENU_DIVISIONS;
      default: m = MENU_TRIGGER;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/bdms_in_if.sv
// Input channel interface: valid/ready plus one event or poll word.
// Depends on bdms_pkg for field widths.
`default_nettype none

interface bdms_in_if;
  logic                           valid;
  logic                           ready;
  logic                           mode;
  logic [bdms_pkg::IDX_W-1:0]     button_index;
  logic                           pin_level;
  logic [bdms_pkg::TICK_IN_W-1:0] tick_ms;
  logic [bdms_pkg::ENC_W-1:0]     encoder_count;

  modport source (output valid, mode, button_index, pin_level, tick_ms, encoder_count,
                  input ready);
  modport sink   (input valid, mode, button_index, pin_level, tick_ms, encoder_count,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/core/bdms_out_if.sv
// Result channel interface: valid/ready plus one status word.
// Depends on bdms_pkg for field widths.
`default_nettype none

interface bdms_out_if;
  logic                          valid;
  logic                          ready;
  logic [bdms_pkg::MENU_W-1:0]   menu_mode;
  logic                          main_pressed;
  logic [bdms_pkg::DIR_W-1:0]    encoder_direction;
  logic [bdms_pkg::STATES_W-1:0] button_states;

  modport source (output valid, menu_mode, main_pressed, encoder_direction, button_states,
                  input ready);
  modport sink   (input valid, menu_mode, main_pressed, encoder_direction, button_states,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/core/bdms_datapath.sv
// Datapath: item capture, per-button stamps and flags, poll scan counter,
// encoder tracking and the result register. Depends on bdms_pkg.
`default_nettype none

module bdms_datapath (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire bdms_pkg::bdms_cmd_t             cmd,
  output bdms_pkg::bdms_sts_t                  sts,
  input  wire logic                            cfg_we,
  input  wire logic [bdms_pkg::CFG_W-1:0]      cfg_data,
  input  wire logic                            in_mode,
  input  wire logic [bdms_pkg::IDX_W-1:0]      in_button_index,
  input  wire logic                            in_pin_level,
  input  wire logic [bdms_pkg::TICK_IN_W-1:0]  in_tick_ms,
  input  wire logic [bdms_pkg::ENC_W-1:0]      in_encoder_count,
  output logic                                 item_poll,
  output logic [bdms_pkg::MENU_W-1:0]          out_menu_mode,
  output logic                                 out_main_pressed,
  output logic [bdms_pkg::DIR_W-1:0]           out_encoder_direction,
  output logic [bdms_pkg::STATES_W-1:0]        out_button_states
);

  localparam int WIDE_W = bdms_pkg::IDX_W + bdms_pkg::BTN_W;

  // Captured item
  logic                             mode_in_r;
  logic [bdms_pkg::IDX_W-1:0]       idx_r;
  logic                             level_r;
  logic [bdms_pkg::TICK_BITS-1:0]   now_r;
  logic [bdms_pkg::ENC_W-1:0]       count_r;

  // Block state
  logic [bdms_pkg::CFG_W-1:0]       debounce_r;
  logic [bdms_pkg::NUM_BUTTONS-1:0] pressed_r;
  logic [bdms_pkg::NUM_BUTTONS-1:0] pending_r;
  logic [bdms_pkg::TICK_BITS-1:0]   press_stamp_r   [bdms_pkg::NUM_BUTTONS];
  logic [bdms_pkg::TICK_BITS-1:0]   release_stamp_r [bdms_pkg::NUM_BUTTONS];
  logic [bdms_pkg::MENU_W-1:0]      menu_r;
  logic                             main_r;
  logic [bdms_pkg::DIR_W-1:0]       dir_r;
  logic [bdms_pkg::ENC_W-1:0]       last_count_r;
  logic [bdms_pkg::BTN_W-1:0]       scan_cnt_r;
  logic                             lock_ok_r;

  // Result register
  logic [bdms_pkg::MENU_W-1:0]      res_menu_r;
  logic                             res_main_r;
  logic [bdms_pkg::DIR_W-1:0]       res_dir_r;
  logic [bdms_pkg::STATES_W-1:0]    res_states_r;

  logic [WIDE_W-1:0]                idx_wide;
  logic                             in_range;
  logic [bdms_pkg::BTN_W-1:0]       sel;
  logic [bdms_pkg::TICK_BITS-1:0]   press_diff;
  logic [bdms_pkg::TICK_BITS-1:0]   release_diff;
  logic [bdms_pkg::TICK_BITS-1:0]   debounce_ext;

  assign idx_wide     = WIDE_W'(idx_r);
  assign in_range     = idx_wide < WIDE_W'(bdms_pkg::NUM_BUTTONS);
  assign sel          = idx_wide[bdms_pkg::BTN_W-1:0];
  assign press_diff   = now_r - press_stamp_r[sel];
  assign release_diff = now_r - release_stamp_r[sel];
  assign debounce_ext = bdms_pkg::TICK_BITS'(debounce_r);

  assign sts.scan_last = (scan_cnt_r == bdms_pkg::BTN_W'(bdms_pkg::NUM_BUTTONS - 1));
  assign item_poll     = (mode_in_r == bdms_pkg::MODE_POLL);

  assign out_menu_mode         = res_menu_r;
  assign out_main_pressed      = res_main_r;
  assign out_encoder_direction = res_dir_r;
  assign out_button_states     = res_states_r;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      mode_in_r <= in_mode;
      idx_r     <= in_button_index;
      level_r   <= in_pin_level;
      now_r     <= in_tick_ms[bdms_pkg::TICK_BITS-1:0];
      count_r   <= in_encoder_count;
    end
    if (cmd.out_load) begin
      res_menu_r   <= menu_r;
      res_main_r   <= main_r;
      res_dir_r    <= dir_r;
      res_states_r <= pressed_r[bdms_pkg::STATES_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r   <= bdms_pkg::DEBOUNCE_RST;
      pressed_r    <= '0;
      pending_r    <= '0;
      menu_r       <= bdms_pkg::MENU_TIMEBASE;
      main_r       <= 1'b0;
      dir_r        <= bdms_pkg::DIR_NONE;
      last_count_r <= '0;
      scan_cnt_r   <= '0;
      lock_ok_r    <= 1'b0;
      for (int i = 0; i < bdms_pkg::NUM_BUTTONS; i++) begin
        press_stamp_r[i]   <= '0;
        release_stamp_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        debounce_r <= cfg_data;
      end
      // Lockout check: both stamps must lie strictly beyond the interval
      if (cmd.ev_cmp) begin
        lock_ok_r <= in_range && (press_diff > debounce_ext) && (release_diff > debounce_ext);
      end
      if (cmd.ev_wr && lock_ok_r) begin
        if (level_r) begin
          press_stamp_r[sel] <= now_r;
          pressed_r[sel]     <= 1'b1;
          pending_r[sel]     <= 1'b1;
        end else begin
          release_stamp_r[sel] <= now_r;
          pressed_r[sel]       <= 1'b0;
        end
      end
      if (cmd.scan_clr) begin
        scan_cnt_r <= '0;
      end else if (cmd.scan_step) begin
        // Apply one pending press per cycle, lowest index first
        if (pending_r[scan_cnt_r]) begin
          if (scan_cnt_r < bdms_pkg::MENU_BUTTONS) begin
            menu_r <= bdms_pkg::menu_of(scan_cnt_r[1:0]);
          end else if (scan_cnt_r == bdms_pkg::ENC_PUSH_BTN) begin
            main_r <= 1'b1;
          end
        end
        pending_r[scan_cnt_r] <= 1'b0;
        scan_cnt_r            <= scan_cnt_r + 1'b1;
      end
      if (cmd.enc_upd && (count_r != last_count_r)) begin
        dir_r        <= (count_r < last_count_r) ? bdms_pkg::DIR_DOWN : bdms_pkg::DIR_UP;
        last_count_r <= count_r;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/bdms_ctrl.sv
// Controller: sequences one word at a time through event or poll steps
// and owns the result valid flag. Depends on bdms_pkg.
`default_nettype none

module bdms_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  input  wire logic                item_poll,
  input  wire bdms_pkg::bdms_sts_t sts,
  output bdms_pkg::bdms_cmd_t      cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EV_CMP = 3'd1;
  localparam logic [2:0] S_EV_WR  = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_ENC    = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       in_fire;
  logic       out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load_item = 1'b1;
          cmd.scan_clr  = 1'b1;
          state_nxt     = S_EV_CMP;
        end
      end
      S_EV_CMP: begin
        if (item_poll) begin
          state_nxt = S_SCAN;
        end else begin
          cmd.ev_cmp = 1'b1;
          state_nxt  = S_EV_WR;
        end
      end
      S_EV_WR: begin
        cmd.ev_wr = 1'b1;
        state_nxt = S_DONE;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_ENC;
        end
      end
      S_ENC: begin
        cmd.enc_upd = 1'b1;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Never overwrite a result that has not been taken
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> out_free)
    else $error("result register overwritten while occupied");

  // One word in flight: an accept always leaves the idle state
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ready)
    else $error("second word accepted while busy");

  // The scan ends on the last button and goes on to the encoder step
  a_scan_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && sts.scan_last) |=> (state_r == S_ENC))
    else $error("poll scan did not finish into encoder step");

  // Every finished word shows up as a valid result next cycle
  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r)
    else $error("loaded result not presented");

endmodule

`default_nettype wire

FILE: rtl/core/button_debounce_menu_select.sv
// Top level of the five-button timestamp-lockout debouncer with menu select.
// Depends on bdms_pkg, bdms_in_if, bdms_out_if, bdms_ctrl, bdms_datapath.
//
//   channel  | dir | handshake        | word
//   ---------+-----+------------------+----------------------------------------
//   in_ch    | in  | valid/ready      | mode, button_index, pin_level, tick_ms,
//            |     |                  | encoder_count
//   out_ch   | out | valid/ready      | menu_mode, main_pressed,
//            |     |                  | encoder_direction, button_states
//   cfg_*    | in  | cfg_we strobe    | cfg_data = debounce_ms
//
// Pin event: compare step, write step, then the final step loads the result register.
// Poll: mode check, scan at one entry per cycle, encoder step, then the final step.
// One word is in work at a time; the next word is taken as soon as the previous
// one is in the result register, even if that result is still waiting.
// A stalled result holds the controller in its final step until out_ch.ready.
// rst_n is synchronous and active low; debounce_ms returns to 50 on reset.
`default_nettype none

module button_debounce_menu_select (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  bdms_in_if.sink                         in_ch,
  bdms_out_if.source                      out_ch,
  input  wire logic                       cfg_we,
  input  wire logic [bdms_pkg::CFG_W-1:0] cfg_data
);

  bdms_pkg::bdms_cmd_t cmd;
  bdms_pkg::bdms_sts_t sts;
  logic                item_poll;

  // Sequencing: accept, run event or poll steps, publish
  bdms_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .item_poll (item_poll),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Stamps, flags, encoder tracking and the result register
  bdms_datapath u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .sts                   (sts),
    .cfg_we                (cfg_we),
    .cfg_data              (cfg_data),
    .in_mode               (in_ch.mode),
    .in_button_index       (in_ch.button_index),
    .in_pin_level          (in_ch.pin_level),
    .in_tick_ms            (in_ch.tick_ms),
    .in_encoder_count      (in_ch.encoder_count),
    .item_poll             (item_poll),
    .out_menu_mode         (out_ch.menu_mode),
    .out_main_pressed      (out_ch.main_pressed),
    .out_encoder_direction (out_ch.encoder_direction),
    .out_button_states     (out_ch.button_states)
  );

endmodule

`default_nettype wire
